// File: design/urks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urks_pkg
// Shared types and constants for the uniform random key set.
// ----------------------------------------------------------------------------
package urks_pkg;

  localparam int Capacity = 256;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CountW   = $clog2(Capacity + 1);
  localparam int KeyW     = 64;
  localparam int DrawW    = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_SAMPLE = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SAMPLE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: design/uniform_random_key_set.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_random_key_set
// Dense set of distinct 64-bit keys with swap-remove delete and uniform
// sampling, held in one single-port RAM.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// command   in         start & !busy      opcode, item_key, random_draw
// result    out        done (one cycle)   status, sampled_key, entry_count
//
// Insert, delete and update scan the RAM one entry per cycle: a miss returns
// once every entry is compared, a hit when its entry compares, and a delete
// hit then moves the last entry into the freed slot (S_MOVE_RD, S_MOVE_WR).
// Sample reads one entry; an empty sample, clear and no-op stay in S_IDLE.
// The single RAM port sets the scan length. Reset empties the set at once.
// The receiver cannot stall; done pulses once per transaction.
// ----------------------------------------------------------------------------
module uniform_random_key_set (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [2:0]                  opcode,
  input  wire logic [urks_pkg::KeyW-1:0]   item_key,
  input  wire logic [urks_pkg::DrawW-1:0]  random_draw,
  output logic                             busy,
  output logic                             done,
  output logic [2:0]                       status,
  output logic [urks_pkg::KeyW-1:0]        sampled_key,
  output logic [8:0]                       entry_count
);
  import urks_pkg::*;

  state_t              state, state_next;
  logic [2:0]          op;
  logic [KeyW-1:0]     key;
  logic [CountW-1:0]   count;
  logic [CountW-1:0]   idx;      // scan address
  logic                rd_pend;  // read data valid for entry idx-1
  logic [AddrW-1:0]    hit_pos;

  logic                we;
  logic [AddrW-1:0]    addr;
  logic [KeyW-1:0]     wdata, rdata;
  logic [DrawW+CountW-1:0] prod;

  urks_ram #(.Width(KeyW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign busy = (state != S_IDLE);
  assign prod = random_draw * count;
  wire   hit  = rd_pend && (rdata == key);
  wire [CountW-1:0] last = count - 1'b1;

  // result register and control
  logic [2:0]        res_st;
  logic              res_fire;
  logic [KeyW-1:0]   res_key;
  logic [CountW-1:0] cnt_next;

  always_comb begin
    state_next = state;
    we = 1'b0;
    addr = idx[AddrW-1:0];
    wdata = key;
    res_fire = 1'b0;
    res_st = ST_OK;
    res_key = '0;
    cnt_next = count;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_SAMPLE) begin
            addr = prod[DrawW +: AddrW];
            if (count == '0) begin
              res_fire = 1'b1;
              res_st = ST_EMPTY;
            end else begin
              state_next = S_SAMPLE;
            end
          end else if (opcode == OP_CLEAR) begin
            res_fire = 1'b1;
            cnt_next = '0;
          end else if (opcode == OP_INSERT || opcode == OP_DELETE
                       || opcode == OP_UPDATE) begin
            state_next = S_SCAN;
          end else begin
            res_fire = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (op == OP_INSERT) begin
            res_fire = 1'b1;
            res_st = ST_PRESENT;
            state_next = S_IDLE;
          end else if (op == OP_UPDATE) begin
            res_fire = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_MOVE_RD;
          end
        end else if (idx >= count) begin
          // the last entry has been compared (or set is empty)
          if (!rd_pend || idx > count || count == '0) begin
            res_fire = 1'b1;
            state_next = S_IDLE;
            if (op == OP_INSERT) begin
              if (count >= CountW'(Capacity)) begin
                res_st = ST_FULL;
              end else begin
                we = 1'b1;
                addr = count[AddrW-1:0];
                cnt_next = count + 1'b1;
              end
            end else begin
              res_st = ST_NOT_FOUND;
            end
          end
        end
      end
      S_MOVE_RD: begin
        addr = last[AddrW-1:0];
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        we = (hit_pos != last[AddrW-1:0]);
        addr = hit_pos;
        wdata = rdata;
        cnt_next = last;
        res_fire = 1'b1;
        state_next = S_IDLE;
      end
      S_SAMPLE: begin
        res_fire = 1'b1;
        res_key = rdata;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      count <= cnt_next;
      done <= res_fire;
      if (state == S_IDLE) begin
        idx <= '0;
        rd_pend <= 1'b0;
      end else if (state == S_SCAN) begin
        if (hit) begin
          hit_pos <= AddrW'(idx - 1'b1);
        end
        rd_pend <= (idx < count);
        if (idx <= count) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // captured command and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op  <= opcode;
      key <= item_key;
    end
    if (res_fire) begin
      status      <= res_st;
      sampled_key <= res_key;
      entry_count <= 9'(cnt_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Capacity)) else $error("count above capacity");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(busy) || !busy) else $error("done while still busy");
  a_move_shrink: assert property (@(posedge clk) disable iff (rst)
    state == S_MOVE_WR |=> count == $past(count) - 1'b1)
    else $error("delete did not shrink count");
`endif
endmodule
`default_nettype wire

// File: design/urks_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urks_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module urks_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: tb/urks_checker.sv
// ----------------------------------------------------------------------------
// urks_checker
// Watches the command and result channels of the key set, keeps its own copy
// of the set, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module urks_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic [2:0]                  opcode,
  input  wire logic [urks_pkg::KeyW-1:0]   item_key,
  input  wire logic [urks_pkg::DrawW-1:0]  random_draw,
  input  wire logic                        done,
  input  wire logic [2:0]                  status,
  input  wire logic [urks_pkg::KeyW-1:0]   sampled_key,
  input  wire logic [8:0]                  entry_count,
  output int                               fail_count,
  output int                               pending_count
);
  import urks_pkg::*;

  typedef struct packed {
    logic [2:0]      st;
    logic [KeyW-1:0] key;
    logic [8:0]      cnt;
  } outcome_t;

  logic [KeyW-1:0] held_keys [Capacity];
  int              held_count;
  outcome_t        outcome_q [$];

  assign pending_count = outcome_q.size();

  // Index of the key among held cells, or held_count if absent
  function automatic int locate_key(logic [KeyW-1:0] k);
    for (int i = 0; i < held_count; i++)
      if (held_keys[i] == k) return i;
    return held_count;
  endfunction

  // Apply one transaction to the shadow set and return its outcome
  function automatic outcome_t apply_command(logic [2:0] op, logic [KeyW-1:0] k,
                                             logic [DrawW-1:0] draw);
    outcome_t  o;
    int        pos;
    bit [63:0] idx;
    o = '0;
    o.st = ST_OK;
    case (op)
      OP_INSERT: begin
        if (locate_key(k) < held_count) o.st = ST_PRESENT;
        else if (held_count >= Capacity) o.st = ST_FULL;
        else begin
          held_keys[held_count] = k;
          held_count++;
        end
      end
      OP_DELETE: begin
        pos = locate_key(k);
        if (pos >= held_count) o.st = ST_NOT_FOUND;
        else begin
          if (pos != held_count - 1) held_keys[pos] = held_keys[held_count - 1];
          held_count--;
        end
      end
      OP_UPDATE: if (locate_key(k) >= held_count) o.st = ST_NOT_FOUND;
      OP_SAMPLE: begin
        if (held_count == 0) o.st = ST_EMPTY;
        else begin
          idx = (64'(draw) * 64'(held_count)) >> 32;
          o.key = held_keys[idx];
        end
      end
      OP_CLEAR: held_count = 0;
      default: ;
    endcase
    o.cnt = 9'(held_count);
    return o;
  endfunction

  // Predict on accepted commands, compare on result strobes
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      held_count = 0;
      outcome_q.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result st=%0d key=%h cnt=%0d", $time,
                   status, sampled_key, entry_count);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (want.st !== status || want.key !== sampled_key ||
              want.cnt !== entry_count) begin
            $display("%0t: mismatch exp st=%0d key=%h cnt=%0d got st=%0d key=%h cnt=%0d",
                     $time, want.st, want.key, want.cnt, status, sampled_key,
                     entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        outcome_q = {outcome_q, apply_command(opcode, item_key, random_draw)};
    end
  end
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random set commands into the key set, with random gaps,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import urks_pkg::*;

  localparam int RandomItems = 1470;
  localparam int CycleLimit  = 3000000;

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic [2:0]        opcode = '0;
  logic [KeyW-1:0]   item_key = '0;
  logic [DrawW-1:0]  random_draw = '0;
  wire               busy, done;
  wire [2:0]         status;
  wire [KeyW-1:0]    sampled_key;
  wire [8:0]         entry_count;
  int                fail_count, pending_count;
  int                cycles = 0;
  logic [KeyW-1:0]   key_pool [16];

  uniform_random_key_set dut (.*);

  urks_checker u_checker (.*);

  always #5 clk = ~clk;

  // Cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one transaction and hold it until accepted; start stays high
  // afterwards so back-to-back commands need no idle cycle
  task automatic send_command(logic [2:0] op, logic [KeyW-1:0] k, logic [DrawW-1:0] d,
                              bit gappy);
    if (gappy)
      while ($urandom_range(99) < 35) begin
        start <= 0;
        @(posedge clk);
      end
    start       <= 1;
    opcode      <= op;
    item_key    <= k;
    random_draw <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int mode;
    logic [2:0] op;
    logic [KeyW-1:0] k;
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty cases, key extremes, duplicate, odd opcodes
    send_command(OP_SAMPLE, '0, '1, 0);
    send_command(OP_DELETE, '1, '0, 0);
    send_command(OP_UPDATE, '0, '0, 0);
    send_command(OP_INSERT, '0, '0, 0);
    send_command(OP_INSERT, '1, '0, 0);
    send_command(OP_INSERT, '1, '0, 0);
    send_command(OP_INSERT, 64'h5555_AAAA_5555_AAAA, '0, 0);
    send_command(OP_UPDATE, '1, '0, 0);
    send_command(OP_SAMPLE, '0, '0, 0);
    send_command(OP_SAMPLE, '0, '1, 0);
    send_command(OP_DELETE, 64'h5555_AAAA_5555_AAAA, '0, 0);
    send_command(OP_DELETE, '0, '0, 0);
    send_command(3'd5, '1, '1, 0);
    send_command(3'd6, '0, '0, 0);
    send_command(3'd7, '1, '0, 0);
    send_command(OP_CLEAR, '1, '1, 0);
    send_command(OP_SAMPLE, '0, 32'h8000_0000, 0);
    // Fill to capacity, overflow, delete an early entry, then clear
    for (int i = 0; i < Capacity; i++) send_command(OP_INSERT, KeyW'(i) << 8, '0, 0);
    send_command(OP_INSERT, 64'h1234, '0, 0);
    send_command(OP_INSERT, '0, '0, 0);
    send_command(OP_SAMPLE, '0, '1, 0);
    send_command(OP_DELETE, KeyW'(7) << 8, '0, 0);
    send_command(OP_CLEAR, '0, '0, 0);

    // Random: pooled keys so deletes and duplicates hit; middle third has no gaps
    for (int n = 0; n < RandomItems; n++) begin
      mode = $urandom_range(99);
      k = (mode < 80) ? key_pool[$urandom_range(15)] : rand_key();
      op = $urandom_range(99) < 2 ? 3'($urandom_range(7)) : 3'($urandom_range(3));
      if ($urandom_range(199) == 0) op = OP_CLEAR;
      send_command(op, k, $urandom, n < 500 || n >= 1000);
    end
    start <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (Capacity + 10) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// File: uniform_random_key_set.f
design/urks_pkg.sv
design/urks_ram.sv
design/uniform_random_key_set.sv
tb/urks_checker.sv
tb/testbench.sv
